### src/timed_state_sequencer_macros.svh
// ----------------------------------------------------------------------------
// timed_state_sequencer_macros
// assertion macros shared by the sequencer modules, clocked on clock and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef TIMED_STATE_SEQUENCER_MACROS_SVH
`define TIMED_STATE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define TSS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// types, codes and sizes shared by the timed state sequencer modules
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

   localparam int MAX_STATES = 16;
   localparam int IDX_W      = $clog2(MAX_STATES);
   localparam int CNT_W      = $clog2(MAX_STATES + 1);
   localparam int DWELL_W    = 16;
   localparam int TURNS_W    = 8;
   localparam int CSR_W      = 16;
   localparam int CSR_ADDR_W = 3;

   // reset value of both reload registers and of the dwell counter
   localparam logic [DWELL_W-1:0] RELOAD_INIT = DWELL_W'(1);

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_ADVANCE  = 2'd1,
      CMD_SCHEDULE = 2'd2,
      CMD_WRITE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      EV_ACK   = 2'd0,
      EV_LEAVE = 2'd1,
      EV_ENTER = 2'd2
   } event_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RUN_ENABLED    = 3'd0,
      CSR_MANUAL_MODE    = 3'd1,
      CSR_STEP_FORWARD   = 3'd2,
      CSR_STATE_COUNT    = 3'd3,
      CSR_DEFAULT_RELOAD = 3'd4,
      CSR_IDLE_RELOAD    = 3'd5
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SEND0,
      ST_SEND1
   } seq_state_type;

   typedef struct packed {
      logic [DWELL_W-1:0] dwell;
      logic [TURNS_W-1:0] turns;
   } entry_type;

   typedef struct packed {
      event_type        ev;
      logic [IDX_W-1:0] st;
      logic             acc;
      logic             last;
   } res_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic exec;
      logic apply_read;
      logic send_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_read;
      logic has_res;
      logic two_res;
   } dp_stat_type;

endpackage

`default_nettype wire

### src/timed_state_sequencer.sv
// ----------------------------------------------------------------------------
// timed_state_sequencer
// timed state table sequencer with tick, manual advance, jump scheduling and
// table write transactions; emits leave, enter and acknowledge events
// ----------------------------------------------------------------------------
// sequence: after accept the controller runs the execute step, then the table
//   read when a state is entered (the entry table read is registered), then
//   hands out each result; a new transaction is taken only back in idle, and
//   each result waits on rsp_tready; a tick with no result ends after execute
// reset: synchronous, active high; clears control state and the entry enable
//   and pending bits, table contents stay undefined until written
`default_nettype none

module timed_state_sequencer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // tuser: command[1:0]
   input  wire logic [1:0]                     req_tuser,
   // tdata: state_index[3:0], dwell_ticks[19:4], repeat_count[27:20],
   //        entry_enabled[28], entry_pending[29], zero[31:30]
   input  wire logic [31:0]                    req_tdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tuser: event_res[1:0]
   output logic [1:0]                          rsp_tuser,
   // tdata: event_state[3:0], accepted[4], zero[7:5]
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic                           csr_we,
   input  wire logic [tss_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [tss_pkg::CSR_W-1:0]      csr_wdata
);

   tss_pkg::dp_cmd_type  dp_cmd;
   tss_pkg::dp_stat_type dp_stat;

   tss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   tss_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .stat      (dp_stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

### src/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// sequencing state machine: takes a transaction, runs the datapath through
// execute and, when a state is entered, table read, then hands out up to two results
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_state_sequencer_macros.svh"

module tss_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire tss_pkg::dp_stat_type stat,
   output tss_pkg::dp_cmd_type       cmd
);

   tss_pkg::seq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         tss_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = tss_pkg::ST_EXEC;
            end
         end
         tss_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (stat.need_read) begin
               state_in = tss_pkg::ST_READ;
            end else if (stat.has_res) begin
               state_in = tss_pkg::ST_SEND0;
            end else begin
               state_in = tss_pkg::ST_IDLE;
            end
         end
         tss_pkg::ST_READ: begin
            cmd.apply_read = 1'b1;
            state_in       = tss_pkg::ST_SEND0;
         end
         tss_pkg::ST_SEND0: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = stat.two_res ? tss_pkg::ST_SEND1 : tss_pkg::ST_IDLE;
            end
         end
         tss_pkg::ST_SEND1: begin
            rsp_tvalid   = 1'b1;
            cmd.send_sel = 1'b1;
            if (rsp_tready) begin
               state_in = tss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tss_pkg::ST_IDLE;
         end
      endcase
   end

   `TSS_ASSERT_NXT(a_accept_then_exec, req_tvalid && req_tready, state_ff == tss_pkg::ST_EXEC, "accepted transaction not executed")
   `TSS_ASSERT_NXT(a_read_then_send, state_ff == tss_pkg::ST_READ, state_ff == tss_pkg::ST_SEND0, "table read not followed by a result")
   `TSS_ASSERT_IMP(a_second_needs_two, state_ff == tss_pkg::ST_SEND1, stat.two_res && ($past(state_ff) == tss_pkg::ST_SEND0 || $past(state_ff) == tss_pkg::ST_SEND1), "second result sent without two results")

endmodule

`default_nettype wire

### src/tss_dpath.sv
// ----------------------------------------------------------------------------
// tss_dpath
// sequencer datapath: control registers, entry table, dwell and turn
// counters, pending search and result registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "timed_state_sequencer_macros.svh"

module tss_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tss_pkg::dp_cmd_type               cmd,
   output tss_pkg::dp_stat_type                   stat,
   input  wire logic [1:0]                        req_tuser,
   input  wire logic [31:0]                       req_tdata,
   output logic [1:0]                             rsp_tuser,
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [tss_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [tss_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int N   = tss_pkg::MAX_STATES;
   localparam int IW  = tss_pkg::IDX_W;
   localparam int CW  = tss_pkg::CNT_W;
   localparam int DW  = tss_pkg::DWELL_W;
   localparam int TW  = tss_pkg::TURNS_W;

   // configuration
   logic          run_ff, run_in, manual_ff, manual_in, fwd_ff, fwd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] dreload_ff, dreload_in, ireload_ff, ireload_in;

   // sequencer state
   logic [N-1:0]  en_ff, en_in, pend_ff, pend_in;
   logic [IW-1:0] cur_ff, cur_in, pos_ff, pos_in, jtgt_ff, jtgt_in;
   logic          cur_valid_ff, cur_valid_in, pos_valid_ff, pos_valid_in;
   logic          jpend_ff, jpend_in, timing_ff, timing_in;
   logic [TW-1:0] turns_ff, turns_in;
   logic [DW-1:0] dwell_ff, dwell_in;

   // held transaction
   tss_pkg::cmd_type cmd_ff;
   logic [IW-1:0]    idx_ff;
   logic [DW-1:0]    idwell_ff;
   logic [TW-1:0]    iturns_ff;
   logic             ien_ff, ipend_ff;

   // results and table read
   tss_pkg::res_type   res_ff [2];
   tss_pkg::res_type   res_in [2];
   logic [1:0]         res_cnt_ff, res_cnt_in;
   logic [IW-1:0]      eidx_ff;
   logic               epend_ff;
   tss_pkg::entry_type mem [N];
   tss_pkg::entry_type rd_ff;

   // decode of the held transaction
   logic [CW-1:0] n_used;
   logic          is_tick, is_adv, is_sched, is_wr, sched_ok, acc_val;
   logic          tick_live, do_handle, repeat_hit, do_switch;
   logic [IW-1:0] pos_next;
   logic [CW-1:0] pos_inc;
   logic [N-1:0]  pend_mask;
   logic [IW-1:0] found_idx;
   logic          found, take_pend, take_pos, enter_hit, leave_sw;
   logic [IW-1:0] enter_idx;
   logic [1:0]    ev_cnt;

   always_comb begin
      n_used    = (count_ff > CW'(N)) ? CW'(N) : count_ff;
      is_tick   = (cmd_ff == tss_pkg::CMD_TICK);
      is_adv    = (cmd_ff == tss_pkg::CMD_ADVANCE);
      is_sched  = (cmd_ff == tss_pkg::CMD_SCHEDULE);
      is_wr     = (cmd_ff == tss_pkg::CMD_WRITE);
      sched_ok  = ({1'b0, idx_ff} < n_used);
      tick_live = is_tick && run_ff && timing_ff;
      do_handle = (tick_live && (dwell_ff == '0)) || (is_adv && run_ff && manual_ff);
      repeat_hit = do_handle && (turns_ff != '0) && cur_valid_ff;
      do_switch  = do_handle && !repeat_hit && (n_used != '0);

      pos_inc = {1'b0, pos_ff} + CW'(1);
      priority if (jpend_ff) begin
         pos_next = jtgt_ff;
      end else if (fwd_ff) begin
         pos_next = (!pos_valid_ff || pos_inc >= n_used) ? '0 : pos_inc[IW-1:0];
      end else begin
         pos_next = (pos_valid_ff && pos_ff != '0) ? pos_ff - IW'(1)
                                                    : IW'(n_used - CW'(1));
      end

      // lowest pending entry among those in use
      for (int i = 0; i < N; i++) begin
         pend_mask[i] = pend_ff[i] && (CW'(i) < n_used);
      end
      found_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (pend_mask[i]) begin
            found_idx = IW'(i);
         end
      end
      found = |pend_mask;

      take_pend = found && en_ff[found_idx];
      take_pos  = !take_pend && ({1'b0, pos_next} < n_used) && en_ff[pos_next];
      enter_hit = do_switch && (take_pend || take_pos);
      enter_idx = take_pend ? found_idx : pos_next;
      leave_sw  = do_switch && cur_valid_ff;

      unique case (cmd_ff)
         tss_pkg::CMD_TICK:     acc_val = 1'b0;
         tss_pkg::CMD_ADVANCE:  acc_val = run_ff;
         tss_pkg::CMD_SCHEDULE: acc_val = sched_ok;
         tss_pkg::CMD_WRITE:    acc_val = 1'b1;
         default:               acc_val = 1'b0;
      endcase

      ev_cnt = repeat_hit ? 2'd2 : (2'(leave_sw) + 2'(enter_hit));
   end

   assign stat.need_read = enter_hit;
   assign stat.has_res   = (ev_cnt != '0) || !is_tick;
   assign stat.two_res   = (res_cnt_ff == 2'd2);

   always_comb begin
      run_in       = run_ff;
      manual_in    = manual_ff;
      fwd_in       = fwd_ff;
      count_in     = count_ff;
      dreload_in   = dreload_ff;
      ireload_in   = ireload_ff;
      en_in        = en_ff;
      pend_in      = pend_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      pos_valid_in = pos_valid_ff;
      jpend_in     = jpend_ff;
      jtgt_in      = jtgt_ff;
      timing_in    = timing_ff;
      turns_in     = turns_ff;
      dwell_in     = dwell_ff;
      res_in       = res_ff;
      res_cnt_in   = res_cnt_ff;

      if (cmd.exec) begin
         if (tick_live) begin
            dwell_in = (dwell_ff == '0) ? dreload_ff : dwell_ff - DW'(1);
         end
         if (repeat_hit) begin
            turns_in = turns_ff - TW'(1);
         end
         if (do_switch) begin
            pos_in       = pos_next;
            pos_valid_in = 1'b1;
            jpend_in     = 1'b0;
            cur_valid_in = 1'b0;
            if (enter_hit) begin
               cur_in       = enter_idx;
               cur_valid_in = 1'b1;
               if (manual_ff) begin
                  timing_in = 1'b0;
               end
               if (take_pend) begin
                  pend_in[found_idx] = 1'b0;
               end
            end else begin
               dwell_in = ireload_ff;
               if (manual_ff) begin
                  timing_in = 1'b1;
               end
            end
         end
         if (is_sched && sched_ok) begin
            jpend_in = 1'b1;
            jtgt_in  = idx_ff;
         end
         if (is_wr) begin
            en_in[idx_ff]   = ien_ff;
            pend_in[idx_ff] = ipend_ff;
         end

         // results in order: leave first, then enter, else a plain acknowledge
         res_cnt_in = (ev_cnt == '0) ? 2'(!is_tick) : ev_cnt;
         res_in[1]  = '{ev: tss_pkg::EV_ENTER, st: repeat_hit ? cur_ff : enter_idx,
                        acc: acc_val, last: 1'b1};
         priority if (repeat_hit || leave_sw) begin
            // a leave with nothing entered afterwards is the last result of the transaction
            res_in[0] = '{ev: tss_pkg::EV_LEAVE, st: cur_ff, acc: acc_val,
                           last: !(repeat_hit || enter_hit)};
         end else if (enter_hit) begin
            res_in[0] = '{ev: tss_pkg::EV_ENTER, st: enter_idx, acc: acc_val,
                           last: 1'b1};
         end else begin
            res_in[0] = '{ev: tss_pkg::EV_ACK, st: idx_ff, acc: acc_val,
                           last: 1'b1};
         end
      end

      // entered entry: dwell and turns come from the table
      if (cmd.apply_read) begin
         dwell_in = rd_ff.dwell;
         if (epend_ff) begin
            if (rd_ff.turns > TW'(1)) begin
               turns_in = rd_ff.turns - TW'(1);
            end else begin
               turns_in      = '0;
               en_in[eidx_ff] = 1'b0;
            end
         end else begin
            turns_in = (rd_ff.turns != '0) ? rd_ff.turns - TW'(1) : '0;
         end
      end

      if (csr_we) begin
         unique case (csr_addr)
            tss_pkg::CSR_RUN_ENABLED: begin
               run_in = csr_wdata[0];
               if (!manual_ff) begin
                  timing_in = csr_wdata[0];
               end
            end
            tss_pkg::CSR_MANUAL_MODE: begin
               manual_in = csr_wdata[0];
               timing_in = !csr_wdata[0];
            end
            tss_pkg::CSR_STEP_FORWARD: begin
               fwd_in = csr_wdata[0];
            end
            tss_pkg::CSR_STATE_COUNT: begin
               count_in = csr_wdata[CW-1:0];
               if (csr_wdata[CW-1:0] == '0) begin
                  en_in        = '0;
                  pend_in      = '0;
                  cur_valid_in = 1'b0;
                  jpend_in     = 1'b0;
                  turns_in     = '0;
               end
            end
            tss_pkg::CSR_DEFAULT_RELOAD: begin
               dreload_in = csr_wdata[DW-1:0];
            end
            tss_pkg::CSR_IDLE_RELOAD: begin
               ireload_in = csr_wdata[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b1;
         manual_ff    <= 1'b0;
         fwd_ff       <= 1'b1;
         count_ff     <= '0;
         dreload_ff   <= tss_pkg::RELOAD_INIT;
         ireload_ff   <= tss_pkg::RELOAD_INIT;
         en_ff        <= '0;
         pend_ff      <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         pos_ff       <= '0;
         pos_valid_ff <= 1'b0;
         jpend_ff     <= 1'b0;
         jtgt_ff      <= '0;
         timing_ff    <= 1'b1;
         turns_ff     <= '0;
         dwell_ff     <= tss_pkg::RELOAD_INIT;
         res_cnt_ff   <= '0;
      end else begin
         run_ff       <= run_in;
         manual_ff    <= manual_in;
         fwd_ff       <= fwd_in;
         count_ff     <= count_in;
         dreload_ff   <= dreload_in;
         ireload_ff   <= ireload_in;
         en_ff        <= en_in;
         pend_ff      <= pend_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
         pos_valid_ff <= pos_valid_in;
         jpend_ff     <= jpend_in;
         jtgt_ff      <= jtgt_in;
         timing_ff    <= timing_in;
         turns_ff     <= turns_in;
         dwell_ff     <= dwell_in;
         res_cnt_ff   <= res_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.load_item) begin
         cmd_ff    <= tss_pkg::cmd_type'(req_tuser);
         idx_ff    <= req_tdata[IW-1:0];
         idwell_ff <= req_tdata[IW+DW-1:IW];
         iturns_ff <= req_tdata[IW+DW+TW-1:IW+DW];
         ien_ff    <= req_tdata[IW+DW+TW];
         ipend_ff  <= req_tdata[IW+DW+TW+1];
      end
      if (cmd.exec) begin
         eidx_ff  <= enter_idx;
         epend_ff <= take_pend;
      end
   end

   // entry table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && is_wr) begin
         mem[idx_ff] <= '{dwell: idwell_ff, turns: iturns_ff};
      end
      if (cmd.exec) begin
         rd_ff <= mem[enter_idx];
      end
   end

   assign rsp_tuser = res_ff[cmd.send_sel].ev;
   assign rsp_tdata = {3'b000, res_ff[cmd.send_sel].acc, res_ff[cmd.send_sel].st};
   assign rsp_tlast = res_ff[cmd.send_sel].last;

   `TSS_ASSERT_NXT(a_read_follows_enter, cmd.exec && stat.need_read, cmd.apply_read, "table read not applied after entering")
   `TSS_ASSERT_IMP(a_read_only_after_exec, cmd.apply_read, $past(cmd.exec), "table read applied without execute")
   `TSS_ASSERT_IMP(a_res_cnt_range, 1'b1, res_cnt_ff != 2'd3, "result count out of range")

endmodule

`default_nettype wire
